@@ hdl/masp_pkg.sv @@
// ----------------------------------------------------------------------------
// masp_pkg: shared types and constants for the archive stream parser
// Phase codes, result kinds, status codes and the front-to-back item format.
// ----------------------------------------------------------------------------
package masp_pkg;

	typedef enum logic [3:0] {
		PH_MAGIC    = 4'd0,
		PH_VERSION  = 4'd1,
		PH_COUNT    = 4'd2,
		PH_PATH_LEN = 4'd3,
		PH_PATH_TXT = 4'd4,
		PH_NAME_LEN = 4'd5,
		PH_NAME_TXT = 4'd6,
		PH_LINKS    = 4'd7,
		PH_REQ_LEN  = 4'd8,
		PH_REQ_TXT  = 4'd9,
		PH_TGT_LEN  = 4'd10,
		PH_TGT_TXT  = 4'd11,
		PH_CODE_LEN = 4'd12,
		PH_CODE_TXT = 4'd13,
		PH_ENTRY    = 4'd14,
		PH_DONE     = 4'd15
	} phase_t;

	localparam logic [2:0] KIND_STRUCT  = 3'd0;
	localparam logic [2:0] KIND_PATH    = 3'd1;
	localparam logic [2:0] KIND_NAME    = 3'd2;
	localparam logic [2:0] KIND_REQ     = 3'd3;
	localparam logic [2:0] KIND_TGT     = 3'd4;
	localparam logic [2:0] KIND_CODE    = 3'd5;
	localparam logic [2:0] KIND_IGNORED = 3'd6;

	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_NOT_ARCH  = 3'd1;
	localparam logic [2:0] ST_BAD_VER   = 3'd2;
	localparam logic [2:0] ST_TRUNC     = 3'd3;
	localparam logic [2:0] ST_NO_ENTRY  = 3'd4;

	localparam logic [3:0] VARINT_MAX_BYTES = 4'd10;
	localparam logic [7:0] MAGIC_0 = 8'h52;
	localparam logic [7:0] MAGIC_1 = 8'h45;
	localparam logic [7:0] MAGIC_2 = 8'h44;
	localparam logic [7:0] MAGIC_3 = 8'h58;

	// one result item
	typedef struct packed {
		logic [2:0]  kind;
		logic [7:0]  text_byte;
		logic [63:0] module_number;
		logic [63:0] link_number;
		logic [63:0] number_value;
		logic        number_done;
		logic        text_end;
		logic [2:0]  status;
		logic        finished;
	} result_t;

	// classified byte handed from front to back
	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} byte_item_t;

endpackage

@@ hdl/masp_if.sv @@
// ----------------------------------------------------------------------------
// masp_in_if / masp_out_if: valid/ready stream channels
// Input carries a byte and last flag; output carries one result item.
// ----------------------------------------------------------------------------
interface masp_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last_byte;
	modport source (output valid, output data_byte, output last_byte, input ready);
	modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface masp_out_if;
	logic        valid;
	logic        ready;
	logic [2:0]  kind;
	logic [7:0]  text_byte;
	logic [63:0] module_number;
	logic [63:0] link_number;
	logic [63:0] number_value;
	logic        number_done;
	logic        text_end;
	logic [2:0]  status;
	logic        finished;
	modport source (output valid, output kind, output text_byte, output module_number,
		output link_number, output number_value, output number_done, output text_end,
		output status, output finished, input ready);
	modport sink (input valid, input kind, input text_byte, input module_number,
		input link_number, input number_value, input number_done, input text_end,
		input status, input finished, output ready);
endinterface

@@ hdl/masp_queue.sv @@
// ----------------------------------------------------------------------------
// masp_queue: two-entry byte queue between front and back
// Lets intake and parsing stall independently at full rate.
// ----------------------------------------------------------------------------
module masp_queue (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    push,
	input  masp_pkg::byte_item_t    push_item,
	output logic                    full,
	input  logic                    pop,
	output logic                    empty,
	output masp_pkg::byte_item_t    head
);
	masp_pkg::byte_item_t mem_q [2];
	logic wptr_q, rptr_q;
	logic [1:0] count_q;

	assign full  = (count_q == 2'd2);
	assign empty = (count_q == 2'd0);
	assign head  = mem_q[rptr_q];

	// store incoming bytes
	always_ff @(posedge clk) begin
		if (push && !full) mem_q[wptr_q] <= push_item;
	end

	// advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= 1'b0;
			rptr_q  <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push && !full) wptr_q <= ~wptr_q;
			if (pop && !empty) rptr_q <= ~rptr_q;
			count_q <= count_q + {1'b0, push && !full} - {1'b0, pop && !empty};
		end
	end
endmodule

@@ hdl/masp_back.sv @@
// ----------------------------------------------------------------------------
// masp_back: archive grammar engine, one byte per cycle unless stalled
// Consumes each queued byte, updates parse state, registers a result.
// ----------------------------------------------------------------------------
module masp_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [7:0]            expected_version,
	input  logic                  in_valid,
	input  masp_pkg::byte_item_t  in_item,
	output logic                  in_pop,
	output logic                  out_valid,
	input  logic                  out_ready,
	output masp_pkg::result_t     out_res
);
	masp_pkg::phase_t phase_q, phase_d;
	logic [1:0]  hpos_q, hpos_d;
	logic [63:0] acc_q, acc_d;
	logic [3:0]  vcnt_q, vcnt_d;
	logic [63:0] trem_q, trem_d;
	logic [63:0] mtot_q, mtot_d, midx_q, midx_d;
	logic [63:0] ltot_q, ltot_d, lidx_q, lidx_d;
	logic [2:0]  err_q, err_d;
	masp_pkg::result_t res_d, res_q;
	logic        ovalid_q;
	logic        step;

	// take a byte when the result slot is free or being drained
	assign in_pop    = in_valid && (!ovalid_q || out_ready);
	assign step      = in_pop;
	assign out_valid = ovalid_q;
	assign out_res   = res_q;

	always_comb begin
		logic [7:0]  b;
		logic [3:0]  n;
		logic [63:0] merged;
		logic [63:0] shifted;
		logic [63:0] trem_m;
		logic        text_done;
		masp_pkg::phase_t after_p;
		b = in_item.data_byte;
		phase_d = phase_q; hpos_d = hpos_q; acc_d = acc_q; vcnt_d = vcnt_q;
		trem_d = trem_q; mtot_d = mtot_q; midx_d = midx_q; ltot_d = ltot_q;
		lidx_d = lidx_q; err_d = err_q;
		res_d = '0;
		res_d.kind = masp_pkg::KIND_IGNORED;
		n = (vcnt_q >= masp_pkg::VARINT_MAX_BYTES) ? 4'd9 : vcnt_q;
		shifted = {57'd0, b[6:0]} << (7 * n);
		merged = acc_q | shifted;
		trem_m = (trem_q != 64'd0) ? trem_q - 64'd1 : trem_q;
		text_done = 1'b0;
		after_p = phase_q;

		if (err_q == masp_pkg::ST_OK && phase_q != masp_pkg::PH_DONE) begin
			res_d.kind = masp_pkg::KIND_STRUCT;
			if (phase_q >= masp_pkg::PH_PATH_LEN && phase_q <= masp_pkg::PH_CODE_TXT)
				res_d.module_number = midx_q;
			if (phase_q >= masp_pkg::PH_REQ_LEN && phase_q <= masp_pkg::PH_TGT_TXT)
				res_d.link_number = lidx_q;
			unique case (phase_q)
				masp_pkg::PH_MAGIC: begin
					logic [7:0] m;
					case (hpos_q)
						2'd0: m = masp_pkg::MAGIC_0;
						2'd1: m = masp_pkg::MAGIC_1;
						2'd2: m = masp_pkg::MAGIC_2;
						default: m = masp_pkg::MAGIC_3;
					endcase
					if (b != m) err_d = masp_pkg::ST_NOT_ARCH;
					else begin
						hpos_d = hpos_q + 2'd1;
						if (hpos_q == 2'd3) phase_d = masp_pkg::PH_VERSION;
					end
				end
				masp_pkg::PH_VERSION: begin
					if (b != expected_version) err_d = masp_pkg::ST_BAD_VER;
					else phase_d = masp_pkg::PH_COUNT;
				end
				masp_pkg::PH_PATH_TXT, masp_pkg::PH_NAME_TXT, masp_pkg::PH_REQ_TXT,
				masp_pkg::PH_TGT_TXT, masp_pkg::PH_CODE_TXT: begin
					case (phase_q)
						masp_pkg::PH_PATH_TXT: res_d.kind = masp_pkg::KIND_PATH;
						masp_pkg::PH_NAME_TXT: res_d.kind = masp_pkg::KIND_NAME;
						masp_pkg::PH_REQ_TXT:  res_d.kind = masp_pkg::KIND_REQ;
						masp_pkg::PH_TGT_TXT:  res_d.kind = masp_pkg::KIND_TGT;
						default:               res_d.kind = masp_pkg::KIND_CODE;
					endcase
					res_d.text_byte = b;
					trem_d = trem_m;
					if (trem_m == 64'd0) begin
						res_d.text_end = 1'b1;
						text_done = 1'b1;
						after_p = phase_q;
					end
				end
				default: begin
					// varint byte
					if (!b[7]) begin
						acc_d = 64'd0; vcnt_d = 4'd0;
						res_d.number_done = 1'b1;
						res_d.number_value = merged;
						case (phase_q)
							masp_pkg::PH_COUNT: begin
								mtot_d = merged; midx_d = 64'd0;
								phase_d = (merged == 64'd0) ? masp_pkg::PH_ENTRY
									: masp_pkg::PH_PATH_LEN;
							end
							masp_pkg::PH_LINKS: begin
								ltot_d = merged; lidx_d = 64'd0;
								phase_d = (merged == 64'd0) ? masp_pkg::PH_CODE_LEN
									: masp_pkg::PH_REQ_LEN;
							end
							masp_pkg::PH_ENTRY: begin
								if (merged >= mtot_q) err_d = masp_pkg::ST_NO_ENTRY;
								else phase_d = masp_pkg::PH_DONE;
							end
							default: begin
								trem_d = merged;
								if (merged == 64'd0) begin
									text_done = 1'b1;
									after_p = masp_pkg::phase_t'(phase_q + 4'd1);
								end else phase_d = masp_pkg::phase_t'(phase_q + 4'd1);
							end
						endcase
					end else if (n + 4'd1 >= masp_pkg::VARINT_MAX_BYTES) begin
						acc_d = 64'd0; vcnt_d = 4'd0;
						err_d = (phase_q == masp_pkg::PH_ENTRY) ? masp_pkg::ST_NO_ENTRY
							: masp_pkg::ST_TRUNC;
					end else begin
						acc_d = merged; vcnt_d = n + 4'd1;
					end
				end
			endcase
			// step past a finished or empty text
			if (text_done) begin
				case (after_p)
					masp_pkg::PH_PATH_TXT: phase_d = masp_pkg::PH_NAME_LEN;
					masp_pkg::PH_NAME_TXT: phase_d = masp_pkg::PH_LINKS;
					masp_pkg::PH_REQ_TXT:  phase_d = masp_pkg::PH_TGT_LEN;
					masp_pkg::PH_TGT_TXT: begin
						lidx_d = lidx_q + 64'd1;
						phase_d = (lidx_q + 64'd1 < ltot_q) ? masp_pkg::PH_REQ_LEN
							: masp_pkg::PH_CODE_LEN;
					end
					default: begin
						midx_d = midx_q + 64'd1;
						phase_d = (midx_q + 64'd1 < mtot_q) ? masp_pkg::PH_PATH_LEN
							: masp_pkg::PH_ENTRY;
					end
				endcase
			end
		end
		// report early end
		if (in_item.last_byte && err_d == masp_pkg::ST_OK && phase_d != masp_pkg::PH_DONE) begin
			if (phase_d == masp_pkg::PH_MAGIC || phase_d == masp_pkg::PH_VERSION)
				err_d = masp_pkg::ST_NOT_ARCH;
			else if (phase_d == masp_pkg::PH_ENTRY) err_d = masp_pkg::ST_NO_ENTRY;
			else err_d = masp_pkg::ST_TRUNC;
		end
		res_d.status = err_d;
		res_d.finished = in_item.last_byte;
		// re-arm after the final byte
		if (in_item.last_byte) begin
			phase_d = masp_pkg::PH_MAGIC; hpos_d = 2'd0; acc_d = 64'd0; vcnt_d = 4'd0;
			trem_d = 64'd0; mtot_d = 64'd0; midx_d = 64'd0; ltot_d = 64'd0;
			lidx_d = 64'd0; err_d = masp_pkg::ST_OK;
		end
	end

	// parse state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= masp_pkg::PH_MAGIC; hpos_q <= 2'd0; acc_q <= 64'd0; vcnt_q <= 4'd0;
			trem_q <= 64'd0; mtot_q <= 64'd0; midx_q <= 64'd0; ltot_q <= 64'd0;
			lidx_q <= 64'd0; err_q <= masp_pkg::ST_OK; ovalid_q <= 1'b0;
		end else begin
			if (step) begin
				phase_q <= phase_d; hpos_q <= hpos_d; acc_q <= acc_d; vcnt_q <= vcnt_d;
				trem_q <= trem_d; mtot_q <= mtot_d; midx_q <= midx_d; ltot_q <= ltot_d;
				lidx_q <= lidx_d; err_q <= err_d;
			end
			if (step) ovalid_q <= 1'b1;
			else if (out_ready) ovalid_q <= 1'b0;
		end
	end

	// hold result
	always_ff @(posedge clk) begin
		if (step) res_q <= res_d;
	end
endmodule

@@ hdl/module_archive_stream_parser.sv @@
// ----------------------------------------------------------------------------
// module_archive_stream_parser: streaming checker for module archives
// Input channel in: one archive byte per transfer with a last-byte flag.
// Output channel out: exactly one result per input byte, in order, giving
// the byte's kind, text echo, module/link indices, varint values and status.
// Configuration: cfg_we/cfg_wdata write expected_version (reset 1); the user must write it only
// while the block is idle, and the block itself does not enforce this.
// A two-entry queue decouples intake from the grammar engine. An accepted
// byte is first stored in the queue, then the engine registers its result.
// Throughput is one byte per cycle while the receiver holds out.ready high,
// as the engine updates its parse counters for each byte it consumes.
// Reset clears all parse state and empties the queue. When the receiver
// stalls, the result register holds, the queue fills, then in.ready drops.
// After the final byte the parse state clears and a new archive may follow.
// ----------------------------------------------------------------------------
module module_archive_stream_parser (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [7:0]         cfg_wdata,
	masp_in_if.sink            in,
	masp_out_if.source         out
);
	logic [7:0] expected_version_q;
	logic q_full, q_empty, q_pop;
	masp_pkg::byte_item_t push_item, head;
	masp_pkg::result_t res;
	logic ovalid;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) expected_version_q <= 8'd1;
		else if (cfg_we) expected_version_q <= cfg_wdata;
	end

	assign in.ready = !q_full;
	assign push_item.data_byte = in.data_byte;
	assign push_item.last_byte = in.last_byte;

	masp_queue u_queue (
		.clk(clk), .arst_n(arst_n),
		.push(in.valid), .push_item(push_item), .full(q_full),
		.pop(q_pop), .empty(q_empty), .head(head)
	);

	masp_back u_back (
		.clk(clk), .arst_n(arst_n), .expected_version(expected_version_q),
		.in_valid(!q_empty), .in_item(head), .in_pop(q_pop),
		.out_valid(ovalid), .out_ready(out.ready), .out_res(res)
	);

	assign out.valid         = ovalid;
	assign out.kind          = res.kind;
	assign out.text_byte     = res.text_byte;
	assign out.module_number = res.module_number;
	assign out.link_number   = res.link_number;
	assign out.number_value  = res.number_value;
	assign out.number_done   = res.number_done;
	assign out.text_end      = res.text_end;
	assign out.status        = res.status;
	assign out.finished      = res.finished;

`ifndef SYNTH
	// echoed text only on text kinds
	a_text_kind: assert property (@(posedge clk) disable iff (!arst_n)
		out.valid && out.text_end |-> (out.kind != masp_pkg::KIND_STRUCT
			&& out.kind != masp_pkg::KIND_IGNORED))
		else $error("text_end on non-text byte");
	// a queued byte is consumed when the result slot frees
	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		!q_empty && !ovalid |-> q_pop)
		else $error("engine idle with byte queued");
	// number value only with completion
	a_num: assert property (@(posedge clk) disable iff (!arst_n)
		out.valid && !out.number_done |-> out.number_value == 64'd0)
		else $error("stray number value");
`endif
endmodule

@@ tb/sv/module_archive_stream_parser_tb.sv @@
// ----------------------------------------------------------------------------
// module_archive_stream_parser_tb: self-checking bench for the archive parser
// Feeds directed and random archives, with random gaps on both channels, and
// compares every result with an in-bench model of the archive grammar.
// ----------------------------------------------------------------------------
module module_archive_stream_parser_tb;

	logic       clk;
	logic       arst_n;
	logic       cfg_we;
	logic [7:0] cfg_wdata;

	masp_in_if  in_ch ();
	masp_out_if out_ch ();

	module_archive_stream_parser dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in        (in_ch.sink),
		.out       (out_ch.source)
	);

	// parser model state
	logic [7:0]        ver_reg;
	masp_pkg::phase_t  ph;
	logic [2:0]        hdr_pos;
	logic [63:0]       acc;
	logic [3:0]        vcnt;
	logic [63:0]       txt_left;
	logic [63:0]       mod_tot, mod_idx, lnk_tot, lnk_idx;
	logic [2:0]        err;

	masp_pkg::byte_item_t pending_bytes[$];
	masp_pkg::result_t    expected_results[$];
	int                   errors;
	int                   sent;
	bit                   mid_drained;
	int                   in_gap, out_gap;

	always #10 clk = ~clk;

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	function automatic void clear_parse();
		ph = masp_pkg::PH_MAGIC; hdr_pos = 3'd0; acc = 64'd0; vcnt = 4'd0;
		txt_left = 64'd0; mod_tot = 64'd0; mod_idx = 64'd0; lnk_tot = 64'd0;
		lnk_idx = 64'd0; err = masp_pkg::ST_OK;
	endfunction

	function automatic void advance_after_text(masp_pkg::phase_t t);
		case (t)
			masp_pkg::PH_PATH_TXT: ph = masp_pkg::PH_NAME_LEN;
			masp_pkg::PH_NAME_TXT: ph = masp_pkg::PH_LINKS;
			masp_pkg::PH_REQ_TXT:  ph = masp_pkg::PH_TGT_LEN;
			masp_pkg::PH_TGT_TXT: begin
				lnk_idx++;
				ph = (lnk_idx < lnk_tot) ? masp_pkg::PH_REQ_LEN : masp_pkg::PH_CODE_LEN;
			end
			default: begin
				mod_idx++;
				ph = (mod_idx < mod_tot) ? masp_pkg::PH_PATH_LEN : masp_pkg::PH_ENTRY;
			end
		endcase
	endfunction

	// classify one byte and advance the grammar
	function automatic masp_pkg::result_t parse_byte(logic [7:0] b, logic last);
		masp_pkg::result_t r;
		masp_pkg::phase_t p;
		logic [3:0] n;
		logic [63:0] v;
		logic [7:0] mg;
		r = '0;
		r.kind = masp_pkg::KIND_IGNORED;
		if (err == masp_pkg::ST_OK && ph != masp_pkg::PH_DONE) begin
			p = ph;
			r.kind = masp_pkg::KIND_STRUCT;
			if (p >= masp_pkg::PH_PATH_LEN && p <= masp_pkg::PH_CODE_TXT)
				r.module_number = mod_idx;
			if (p >= masp_pkg::PH_REQ_LEN && p <= masp_pkg::PH_TGT_TXT)
				r.link_number = lnk_idx;
			if (p == masp_pkg::PH_MAGIC) begin
				case (hdr_pos[1:0])
					2'd0: mg = masp_pkg::MAGIC_0;
					2'd1: mg = masp_pkg::MAGIC_1;
					2'd2: mg = masp_pkg::MAGIC_2;
					default: mg = masp_pkg::MAGIC_3;
				endcase
				if (b != mg) err = masp_pkg::ST_NOT_ARCH;
				else begin
					hdr_pos++;
					if (hdr_pos >= 3'd4) begin
						hdr_pos = 3'd0; ph = masp_pkg::PH_VERSION;
					end
				end
			end else if (p == masp_pkg::PH_VERSION) begin
				if (b != ver_reg) err = masp_pkg::ST_BAD_VER;
				else ph = masp_pkg::PH_COUNT;
			end else if (p == masp_pkg::PH_PATH_TXT || p == masp_pkg::PH_NAME_TXT ||
					p == masp_pkg::PH_REQ_TXT || p == masp_pkg::PH_TGT_TXT ||
					p == masp_pkg::PH_CODE_TXT) begin
				case (p)
					masp_pkg::PH_PATH_TXT: r.kind = masp_pkg::KIND_PATH;
					masp_pkg::PH_NAME_TXT: r.kind = masp_pkg::KIND_NAME;
					masp_pkg::PH_REQ_TXT:  r.kind = masp_pkg::KIND_REQ;
					masp_pkg::PH_TGT_TXT:  r.kind = masp_pkg::KIND_TGT;
					default:               r.kind = masp_pkg::KIND_CODE;
				endcase
				r.text_byte = b;
				if (txt_left > 64'd0) txt_left--;
				if (txt_left == 64'd0) begin
					r.text_end = 1'b1; advance_after_text(p);
				end
			end else begin
				// varint byte
				n = (vcnt >= masp_pkg::VARINT_MAX_BYTES) ?
					masp_pkg::VARINT_MAX_BYTES - 4'd1 : vcnt;
				acc = acc | ({57'd0, b[6:0]} << (7 * n));
				if (!b[7]) begin
					v = acc; acc = 64'd0; vcnt = 4'd0;
					r.number_done = 1'b1; r.number_value = v;
					if (p == masp_pkg::PH_COUNT) begin
						mod_tot = v; mod_idx = 64'd0;
						ph = (v == 64'd0) ? masp_pkg::PH_ENTRY : masp_pkg::PH_PATH_LEN;
					end else if (p == masp_pkg::PH_LINKS) begin
						lnk_tot = v; lnk_idx = 64'd0;
						ph = (v == 64'd0) ? masp_pkg::PH_CODE_LEN : masp_pkg::PH_REQ_LEN;
					end else if (p == masp_pkg::PH_ENTRY) begin
						if (v >= mod_tot) err = masp_pkg::ST_NO_ENTRY;
						else ph = masp_pkg::PH_DONE;
					end else begin
						txt_left = v;
						if (v == 64'd0) advance_after_text(masp_pkg::phase_t'(p + 4'd1));
						else ph = masp_pkg::phase_t'(p + 4'd1);
					end
				end else begin
					vcnt = n + 4'd1;
					if (vcnt >= masp_pkg::VARINT_MAX_BYTES) begin
						acc = 64'd0; vcnt = 4'd0;
						err = (p == masp_pkg::PH_ENTRY) ? masp_pkg::ST_NO_ENTRY
							: masp_pkg::ST_TRUNC;
					end
				end
			end
		end
		if (last && err == masp_pkg::ST_OK && ph != masp_pkg::PH_DONE) begin
			if (ph == masp_pkg::PH_MAGIC || ph == masp_pkg::PH_VERSION)
				err = masp_pkg::ST_NOT_ARCH;
			else if (ph == masp_pkg::PH_ENTRY) err = masp_pkg::ST_NO_ENTRY;
			else err = masp_pkg::ST_TRUNC;
		end
		r.status = err;
		r.finished = last;
		if (last) clear_parse();
		return r;
	endfunction

	// queue a byte and its expected result
	task automatic push_byte(logic [7:0] b, logic last = 1'b0);
		masp_pkg::byte_item_t it;
		it.data_byte = b;
		it.last_byte = last;
		pending_bytes = {pending_bytes, it};
		expected_results = {expected_results, parse_byte(b, last)};
		sent++;
	endtask

	task automatic push_varint(logic [63:0] v);
		do begin
			push_byte({(v >> 7) != 64'd0, v[6:0]});
			v = v >> 7;
		end while (v != 64'd0);
	endtask

	task automatic push_text(int len);
		push_varint(64'(len));
		for (int i = 0; i < len; i++) push_byte(8'($urandom_range(0, 255)));
	endtask

	task automatic push_header();
		push_byte(masp_pkg::MAGIC_0); push_byte(masp_pkg::MAGIC_1);
		push_byte(masp_pkg::MAGIC_2); push_byte(masp_pkg::MAGIC_3);
		push_byte(ver_reg);
	endtask

	// build a well-formed archive with random content, optionally damaged
	task automatic push_archive(int mods, bit damage);
		int cut;
		push_header();
		push_varint(64'(mods));
		for (int m = 0; m < mods; m++) begin
			int nl;
			push_text($urandom_range(0, 4));
			push_text($urandom_range(0, 4));
			nl = $urandom_range(0, 2);
			push_varint(64'(nl));
			for (int l = 0; l < nl; l++) begin
				push_text($urandom_range(0, 3));
				push_text($urandom_range(0, 3));
			end
			push_text($urandom_range(0, 5));
		end
		if (damage) begin
			cut = $urandom_range(0, 3);
			if (cut == 0) push_varint(64'(mods + $urandom_range(0, 3)));
			if (cut == 1)
				for (int i = 0; i < 10; i++) push_byte(8'h80 | 8'($urandom_range(0, 127)));
			push_byte(8'($urandom_range(0, 255)), 1'b1);
		end else begin
			push_varint(mods == 0 ? 64'd0 : 64'($urandom_range(0, mods - 1)));
			repeat ($urandom_range(0, 2)) push_byte(8'($urandom_range(0, 255)));
			push_byte(8'($urandom_range(0, 255)), 1'b1);
		end
	endtask

	task automatic wait_drained();
		while (pending_bytes.size() != 0 || expected_results.size() != 0) @(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	task automatic write_version(logic [7:0] v);
		@(negedge clk);
		cfg_we = 1'b1; cfg_wdata = v;
		@(negedge clk);
		cfg_we = 1'b0;
		ver_reg = v;
	endtask

	// note input transfers for the driver
	logic in_taken;
	always @(posedge clk) in_taken <= in_ch.valid && in_ch.ready;

	// drive input transfers
	always @(negedge clk) begin
		if (!arst_n) begin
			in_ch.valid <= 1'b0;
			in_gap = 0;
		end else begin
			if (in_taken) void'(pending_bytes.pop_front());
			if (in_ch.valid && !in_taken) begin
				// hold until accepted
			end else if (in_gap > 0) begin
				in_gap--;
				in_ch.valid <= 1'b0;
			end else if (pending_bytes.size() > 0) begin
				in_ch.valid <= 1'b1;
				in_ch.data_byte <= pending_bytes[0].data_byte;
				in_ch.last_byte <= pending_bytes[0].last_byte;
				in_gap = gap_len();
			end else in_ch.valid <= 1'b0;
		end
	end

	// check result transfers
	always @(posedge clk) begin
		masp_pkg::result_t act, exp_r;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			act = {out_ch.kind, out_ch.text_byte, out_ch.module_number, out_ch.link_number,
				out_ch.number_value, out_ch.number_done, out_ch.text_end, out_ch.status,
				out_ch.finished};
			if (expected_results.size() == 0) begin
				$display("%0t: unexpected result %h", $time, act);
				errors++;
			end else begin
				exp_r = expected_results.pop_front();
				if (act !== exp_r) begin
					$display("%0t: mismatch expected %h actual %h", $time, exp_r, act);
					$display("  kind %0d/%0d status %0d/%0d value %0d/%0d", exp_r.kind,
						act.kind, exp_r.status, act.status, exp_r.number_value,
						act.number_value);
					errors++;
				end
			end
		end
	end

	// receiver stalls
	always @(negedge clk) begin
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
			out_gap = 0;
		end else if (out_gap > 0) begin
			out_gap--;
			out_ch.ready <= 1'b0;
		end else begin
			out_ch.ready <= 1'b1;
			if ($urandom_range(0, 3) == 0) out_gap = gap_len();
		end
	end

	initial begin
		#3000000;
		$display("TEST FAILED");
		$finish;
	end

	initial begin
		clk = 1'b0; arst_n = 1'b0; cfg_we = 1'b0; cfg_wdata = 8'd0;
		in_ch.valid = 1'b0; in_ch.data_byte = 8'd0; in_ch.last_byte = 1'b0;
		out_ch.ready = 1'b0;
		errors = 0; sent = 0; mid_drained = 1'b0; ver_reg = 8'd1;
		clear_parse();
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: good, bad magic, short, bad version, empty, long varint
		push_archive(1, 0);
		push_byte(masp_pkg::MAGIC_0); push_byte(8'h00); push_byte(8'hff, 1'b1);
		push_byte(masp_pkg::MAGIC_0); push_byte(masp_pkg::MAGIC_1, 1'b1);
		push_byte(masp_pkg::MAGIC_0); push_byte(masp_pkg::MAGIC_1);
		push_byte(masp_pkg::MAGIC_2); push_byte(masp_pkg::MAGIC_3);
		push_byte(8'h07, 1'b1);
		push_header(); push_varint(64'd0); push_varint(64'd0); push_byte(8'h11, 1'b1);
		push_header();
		for (int i = 0; i < 9; i++) push_byte(8'hff);
		push_byte(8'h01); push_varint(64'd0); push_byte(8'h00, 1'b1);
		wait_drained();

		write_version(8'h00);
		push_archive(2, 0);
		push_header();
		for (int i = 0; i < 10; i++) push_byte(8'hff);
		push_byte(8'h00, 1'b1);
		wait_drained();
		write_version(8'hff);
		push_archive(1, 1);
		push_archive(3, 0);
		wait_drained();
		write_version(8'($urandom_range(0, 255)));

		// random: mostly well-formed archives, some damaged, some noise
		while (sent < 700) begin
			int sel;
			sel = $urandom_range(0, 9);
			if (sel < 6) push_archive($urandom_range(0, 3), 0);
			else if (sel < 9) push_archive($urandom_range(0, 3), 1);
			else repeat ($urandom_range(1, 6))
				push_byte(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
			if (!mid_drained && sent >= 350) begin
				mid_drained = 1'b1;
				wait_drained();
				write_version(8'd1);
			end
		end
		push_byte(8'($urandom_range(0, 255)), 1'b1);
		wait_drained();
		if (errors == 0) $display("TEST PASSED");
		else $display("TEST FAILED");
		$finish;
	end

endmodule

@@ sim.f @@
hdl/masp_pkg.sv
hdl/masp_if.sv
hdl/masp_queue.sv
hdl/masp_back.sv
hdl/module_archive_stream_parser.sv
tb/sv/module_archive_stream_parser_tb.sv
